@@ hdl/stq_pkg.sv @@
// Shared types and constants for the sorted time queue.
`default_nettype none

package stq_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int TAG_BITS   = 16;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int ENTRY_BITS = KEY_BITS + TAG_BITS;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_BITS-1:0] key_time;
    logic [TAG_BITS-1:0] payload_tag;
  } in_word_t;

  typedef struct packed {
    status_t             status;
    logic [KEY_BITS-1:0] front_time;
    logic [TAG_BITS-1:0] front_tag;
    logic [CNT_BITS-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/sorted_time_queue_core.sv @@
// Sorted time queue: bounded priority queue kept in ascending key order.
//
// Input channel in_valid/in_ready/in_word carries a push (key and tag) or a
// pop. Result channel out_valid/out_ready/out_word returns one word per item:
// status, popped key and tag (zero unless a pop succeeded) and the count of
// stored entries afterwards. Equal keys leave in arrival order.
// Entries live in a circular buffer RAM; a pop reads the head slot, a push
// walks back from the tail, moving each larger entry up one slot through a
// single key comparator, one entry per cycle, then writes the new entry.
// One item is worked at a time; in_ready is high only while idle.
// A rejected item and a push into an empty queue go from accept straight to
// S_OUT; a pop passes through S_POPRD, and any other push through S_SCAN,
// and S_INS0 as well when the new key is smaller than every stored key.
// The next item is accepted as soon as the result has been loaded into the
// output register, even while the receiver holds out_ready low; a further
// result then waits until the output register is taken.
// Reset empties the queue at once; RAM contents need no clearing.
`default_nettype none

module sorted_time_queue_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire stq_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output stq_pkg::out_word_t     out_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS0,
    S_POPRD,
    S_OUT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [stq_pkg::IDX_BITS-1:0]     idx_r, idx_nxt;
  logic [stq_pkg::IDX_BITS-1:0]     head_r, head_nxt;
  logic [stq_pkg::CNT_BITS-1:0]     count_r, count_nxt;
  logic [stq_pkg::KEY_BITS-1:0]     key_r, key_nxt;
  logic [stq_pkg::TAG_BITS-1:0]     tag_r, tag_nxt;
  stq_pkg::out_word_t               res_r, res_nxt;
  logic                             out_valid_r, out_valid_nxt;
  stq_pkg::out_word_t               out_word_r, out_word_nxt;

  logic                             ram_we;
  logic [stq_pkg::IDX_BITS-1:0]     ram_waddr;
  stq_pkg::entry_t                  ram_wdata;
  logic                             ram_re;
  logic [stq_pkg::IDX_BITS-1:0]     ram_raddr;
  logic [stq_pkg::ENTRY_BITS-1:0]   ram_rdata;
  stq_pkg::entry_t                  rd_entry;
  logic                             key_gt;
  logic                             accept;

  function automatic logic [stq_pkg::IDX_BITS-1:0] slot_addr(
    input logic [stq_pkg::IDX_BITS-1:0] base,
    input logic [stq_pkg::IDX_BITS-1:0] off
  );
    logic [stq_pkg::IDX_BITS:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (stq_pkg::IDX_BITS + 1)'(stq_pkg::DEPTH)) begin
      sum = sum - (stq_pkg::IDX_BITS + 1)'(stq_pkg::DEPTH);
    end
    return sum[stq_pkg::IDX_BITS-1:0];
  endfunction

  stq_ram #(
    .WIDTH (stq_pkg::ENTRY_BITS),
    .DEPTH (stq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = stq_pkg::entry_t'(ram_rdata);
  assign key_gt   = rd_entry.key > key_r;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    tag_nxt       = tag_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '{key: key_r, tag: tag_r};
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_word.key_time;
          tag_nxt = in_word.payload_tag;
          res_nxt = '{status: stq_pkg::ST_DONE, front_time: '0, front_tag: '0,
                      entry_count: count_r};
          if (in_word.op == stq_pkg::OP_PUSH) begin
            if (count_r == stq_pkg::CNT_BITS'(stq_pkg::DEPTH)) begin
              res_nxt.status = stq_pkg::ST_FULL;
              state_nxt      = S_OUT;
            end else if (count_r == '0) begin
              ram_we              = 1'b1;
              ram_waddr           = head_r;
              ram_wdata           = '{key: in_word.key_time, tag: in_word.payload_tag};
              count_nxt           = count_r + 1'b1;
              res_nxt.entry_count = count_r + 1'b1;
              state_nxt           = S_OUT;
            end else begin
              idx_nxt   = stq_pkg::IDX_BITS'(count_r - 1'b1);
              ram_re    = 1'b1;
              ram_raddr = slot_addr(head_r, stq_pkg::IDX_BITS'(count_r - 1'b1));
              state_nxt = S_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = stq_pkg::ST_EMPTY;
              state_nxt      = S_OUT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
              state_nxt = S_POPRD;
            end
          end
        end
      end
      S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(head_r, idx_r + 1'b1);
        if (key_gt) begin
          ram_wdata = rd_entry;
          if (idx_r == '0) begin
            state_nxt = S_INS0;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            ram_re    = 1'b1;
            ram_raddr = slot_addr(head_r, idx_r - 1'b1);
          end
        end else begin
          count_nxt           = count_r + 1'b1;
          res_nxt.entry_count = count_r + 1'b1;
          state_nxt           = S_OUT;
        end
      end
      S_INS0: begin
        ram_we              = 1'b1;
        ram_waddr           = head_r;
        count_nxt           = count_r + 1'b1;
        res_nxt.entry_count = count_r + 1'b1;
        state_nxt           = S_OUT;
      end
      S_POPRD: begin
        res_nxt.front_time  = rd_entry.key;
        res_nxt.front_tag   = rd_entry.tag;
        res_nxt.entry_count = count_r - 1'b1;
        count_nxt           = count_r - 1'b1;
        head_nxt            = slot_addr(head_r, stq_pkg::IDX_BITS'(1));
        state_nxt           = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    tag_r      <= tag_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

@@ hdl/stq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/stq_checker.sv @@
// Port-level checks for the sorted time queue, bound to the top level.
`default_nettype none

module stq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire stq_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  a_zero_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != stq_pkg::ST_DONE |->
      out_word.front_time == '0 && out_word.front_tag == '0)
    else $error("rejected item returned a nonzero entry");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == stq_pkg::ST_EMPTY |-> out_word.entry_count == '0)
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == stq_pkg::ST_FULL |->
      out_word.entry_count == stq_pkg::CNT_BITS'(stq_pkg::DEPTH))
    else $error("full status with count below depth");

endmodule

bind sorted_time_queue_core stq_checker u_stq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
